// ===== rtl/bud_pkg.sv =====
package bud_pkg;
   localparam int POOL_BYTES_DEF    = 1024;
   localparam int NUM_ORDERS_DEF    = 11;
   localparam int TABLE_ENTRIES_DEF = 64;
   localparam int SMALL_LIMIT_DEF   = 8;
   localparam int TAG_BITS_DEF      = 16;

   localparam int STATUS_BITS = 3;
   localparam int OFFSET_BITS = 10;
   localparam int ORDER_BITS  = 4;
   localparam int SIZE_BITS   = 11;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK         = 3'd0,
      ST_NO_FREE    = 3'd1,
      ST_TOO_LARGE  = 3'd2,
      ST_TABLE_FULL = 3'd3,
      ST_NOT_FOUND  = 3'd4
   } status_type;

   typedef struct packed {
      status_type             status;
      logic [OFFSET_BITS-1:0] offset;
      logic [ORDER_BITS-1:0]  order;
   } result_type;
endpackage

// ===== rtl/bud_table.sv =====
// allocation table: tag/offset/order memory plus valid bits, read one entry at a time
module bud_table #(
   parameter int TABLE_ENTRIES = bud_pkg::TABLE_ENTRIES_DEF,
   parameter int TAG_BITS      = bud_pkg::TAG_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr,
   output logic                          rd_valid,
   output logic [TAG_BITS-1:0]           rd_tag,
   output logic [bud_pkg::OFFSET_BITS-1:0] rd_offset,
   output logic [bud_pkg::ORDER_BITS-1:0]  rd_order,
   input  logic                          wr_en,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] wr_addr,
   input  logic [TAG_BITS-1:0]           wr_tag,
   input  logic [bud_pkg::OFFSET_BITS-1:0] wr_offset,
   input  logic [bud_pkg::ORDER_BITS-1:0]  wr_order,
   input  logic                          clr_en,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] clr_addr
);
   localparam int DW = TAG_BITS + bud_pkg::OFFSET_BITS + bud_pkg::ORDER_BITS;
   logic [DW-1:0] mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [DW-1:0] rdata_ff;
   logic rvalid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= {wr_tag, wr_offset, wr_order};
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         rvalid_ff <= valid_ff[rd_addr];
         if (wr_en) valid_ff[wr_addr] <= 1'b1;
         if (clr_en) valid_ff[clr_addr] <= 1'b0;
      end
   end

   assign rd_valid  = rvalid_ff;
   assign rd_tag    = rdata_ff[DW-1 -: TAG_BITS];
   assign rd_offset = rdata_ff[bud_pkg::ORDER_BITS +: bud_pkg::OFFSET_BITS];
   assign rd_order  = rdata_ff[bud_pkg::ORDER_BITS-1:0];
endmodule

// ===== rtl/bud_freemap.sv =====
// free bitmap of buddy-tree nodes; one read and one write port, cleared by a sweep after reset
module bud_freemap #(
   parameter int NUM_ORDERS = bud_pkg::NUM_ORDERS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [NUM_ORDERS-1:0] rd_addr,
   output logic                  rd_data,
   input  logic                  wr_en,
   input  logic [NUM_ORDERS-1:0] wr_addr,
   input  logic                  wr_data,
   output logic                  busy
);
   localparam int NODES = 1 << NUM_ORDERS;
   logic mem [NODES];
   logic rd_ff;
   logic [NUM_ORDERS-1:0] clr_addr_ff;
   logic clr_busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clr_busy_ff <= 1'b1;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == '1) clr_busy_ff <= 1'b0;
      end
   end

   // sweep leaves only the whole-pool node free
   always_ff @(posedge clock) begin
      if (clr_busy_ff) mem[clr_addr_ff] <= (clr_addr_ff == '0);
      else if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;
   assign busy    = clr_busy_ff;
endmodule

// ===== rtl/buddy_allocator.sv =====
// buddy allocator over a pool of POOL_BYTES bytes
// input channel req_: one transfer per request; tdata = {tag, request_size},
//   tuser = kind (0 allocate, 1 free)
// result channel rsp_: one transfer per request; tdata = {order, offset, status}
// the block handles one request at a time. an allocate scans the table for a
// free slot (one memory read per entry, up to TABLE_ENTRIES entries), then
// scans the free bitmap order by order, node by node, then writes the split
// halves one order per cycle. a free scans the table for the tag the same way,
// then walks up merging buddies order by order; with a fragmented pool the
// bitmap walk dominates.
// after reset the table valid bits are cleared and the free bitmap runs
// a clearing sweep over all 2^NUM_ORDERS nodes (2048 by default) that leaves only the
// whole-pool block free; req_tready stays low until the sweep ends
// the result sits in an output register; req_tready stays low until the
// result has been taken, so a stalled receiver simply holds the block
module buddy_allocator #(
   parameter int POOL_BYTES    = bud_pkg::POOL_BYTES_DEF,
   parameter int NUM_ORDERS    = bud_pkg::NUM_ORDERS_DEF,
   parameter int TABLE_ENTRIES = bud_pkg::TABLE_ENTRIES_DEF,
   parameter int SMALL_LIMIT   = bud_pkg::SMALL_LIMIT_DEF,
   parameter int TAG_BITS      = bud_pkg::TAG_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [((TAG_BITS+11+7)/8)*8-1:0] req_tdata, // request_size, tag
   input  logic req_tuser,                              // kind
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [23:0] rsp_tdata                        // status, block_offset, block_order
);
   localparam int TOP = NUM_ORDERS - 1;
   localparam int NB  = NUM_ORDERS;
   localparam int EB  = $clog2(TABLE_ENTRIES);
   localparam int OB  = bud_pkg::ORDER_BITS;
   localparam int OFB = bud_pkg::OFFSET_BITS;

   typedef enum logic [3:0] {
      S_IDLE, S_SLOT_RD, S_SLOT_CHK, S_MAP_RD, S_MAP_CHK, S_SPLIT,
      S_TAG_RD, S_TAG_CHK, S_MRG_RD, S_MRG_CHK, S_DONE
   } state_type;

   state_type state_ff;
   logic [TAG_BITS-1:0] tag_ff;
   logic [OB-1:0] want_ff, ord_ff, rel_ord_ff;
   logic [NB-1:0] off_ff, rel_off_ff;      // byte offset, pool width
   logic [EB:0] idx_ff;
   logic [NB-1:0] k_ff;                     // block index within order
   logic rsp_valid_ff;
   bud_pkg::result_type res_ff;

   // request decode
   logic [bud_pkg::SIZE_BITS-1:0] size_w;
   logic [bud_pkg::SIZE_BITS-1:0] rounded_w;
   logic [OB-1:0] want_w;
   assign size_w    = req_tdata[bud_pkg::SIZE_BITS-1:0];
   assign rounded_w = (size_w < bud_pkg::SIZE_BITS'(SMALL_LIMIT)) ?
                      bud_pkg::SIZE_BITS'(2*SMALL_LIMIT) : size_w;
   always_comb begin
      want_w = '0;
      for (int i = bud_pkg::SIZE_BITS; i >= 0; i--)
         if ((32'd1 << i) >= 32'(rounded_w)) want_w = OB'(i);
   end

   function automatic logic [NB-1:0] node_of(input logic [OB-1:0] o,
                                              input logic [NB-1:0] off);
      logic [NB-1:0] n;
      n = NB'((32'd1 << (TOP - 32'(o))) - 1) + NB'(off >> o);
      return n;
   endfunction

   // table
   logic t_valid;
   logic [TAG_BITS-1:0] t_tag;
   logic [OFB-1:0] t_off;
   logic [OB-1:0] t_ord;
   logic t_wr, t_clr;
   bud_table #(.TABLE_ENTRIES(TABLE_ENTRIES), .TAG_BITS(TAG_BITS)) u_table (
      .clock, .reset, .rd_addr(idx_ff[EB-1:0]),
      .rd_valid(t_valid), .rd_tag(t_tag), .rd_offset(t_off), .rd_order(t_ord),
      .wr_en(t_wr), .wr_addr(idx_ff[EB-1:0]), .wr_tag(tag_ff),
      .wr_offset(OFB'(off_ff)), .wr_order(want_ff),
      .clr_en(t_clr), .clr_addr(idx_ff[EB-1:0]));

   // free bitmap
   logic [NB-1:0] m_rd_addr, m_wr_addr;
   logic m_rd, m_wr, m_wdata, m_busy;
   bud_freemap #(.NUM_ORDERS(NUM_ORDERS)) u_map (
      .clock, .reset, .rd_addr(m_rd_addr), .rd_data(m_rd),
      .wr_en(m_wr), .wr_addr(m_wr_addr), .wr_data(m_wdata), .busy(m_busy));

   logic [NB-1:0] blk_off_w, buddy_w, split_off_w;
   assign blk_off_w   = NB'(k_ff << ord_ff);
   assign buddy_w     = off_ff ^ NB'(1 << ord_ff);
   // lower half at order ord_ff-1 of the block being split (top pieces granted)
   assign split_off_w = off_ff;

   always_comb begin
      m_rd_addr = (state_ff == S_MRG_RD) ? node_of(ord_ff, buddy_w)
                                         : node_of(ord_ff, blk_off_w);
      m_wr = 1'b0; m_wr_addr = '0; m_wdata = 1'b0;
      t_wr = 1'b0; t_clr = 1'b0;
      unique case (state_ff)
         S_MAP_CHK: if (m_rd) begin
            m_wr = 1'b1; m_wr_addr = node_of(ord_ff, blk_off_w);
         end
         S_SPLIT: if (ord_ff > want_ff) begin
            m_wr = 1'b1; m_wdata = 1'b1;
            m_wr_addr = node_of(ord_ff - 1'b1, split_off_w);
         end else t_wr = 1'b1;
         S_TAG_CHK: t_clr = t_valid && t_tag == tag_ff;
         S_MRG_CHK: begin
            m_wr = 1'b1;
            if (m_rd && 32'(ord_ff) < TOP) m_wr_addr = node_of(ord_ff, buddy_w);
            else begin m_wdata = 1'b1; m_wr_addr = node_of(ord_ff, off_ff); end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req_tvalid && !rsp_valid_ff && !m_busy) begin
               tag_ff  <= req_tdata[bud_pkg::SIZE_BITS +: TAG_BITS];
               want_ff <= want_w;
               idx_ff  <= '0;
               if (!req_tuser && (32'(size_w) > POOL_BYTES || 32'(want_w) > TOP)) begin
                  res_ff <= '{bud_pkg::ST_TOO_LARGE, '0, '0};
                  state_ff <= S_DONE;
               end else state_ff <= req_tuser ? S_TAG_RD : S_SLOT_RD;
            end
            S_SLOT_RD: state_ff <= S_SLOT_CHK;
            S_SLOT_CHK: if (!t_valid) begin
               ord_ff <= want_ff; k_ff <= '0; state_ff <= S_MAP_RD;
            end else if (32'(idx_ff) == TABLE_ENTRIES - 1) begin
               res_ff <= '{bud_pkg::ST_TABLE_FULL, '0, '0}; state_ff <= S_DONE;
            end else begin
               idx_ff <= idx_ff + 1'b1; state_ff <= S_SLOT_RD;
            end
            S_MAP_RD: state_ff <= S_MAP_CHK;
            S_MAP_CHK: if (m_rd) begin
               off_ff <= blk_off_w; state_ff <= S_SPLIT;
            end else if (32'(k_ff) == (1 << (TOP - 32'(ord_ff))) - 1) begin
               if (32'(ord_ff) == TOP) begin
                  res_ff <= '{bud_pkg::ST_NO_FREE, '0, '0}; state_ff <= S_DONE;
               end else begin
                  ord_ff <= ord_ff + 1'b1; k_ff <= '0; state_ff <= S_MAP_RD;
               end
            end else begin
               k_ff <= k_ff + 1'b1; state_ff <= S_MAP_RD;
            end
            S_SPLIT: if (ord_ff > want_ff) begin
               off_ff <= off_ff + NB'(1 << (ord_ff - 1'b1));
               ord_ff <= ord_ff - 1'b1;
            end else begin
               res_ff <= '{bud_pkg::ST_OK, OFB'(off_ff), want_ff};
               state_ff <= S_DONE;
            end
            S_TAG_RD: state_ff <= S_TAG_CHK;
            S_TAG_CHK: if (t_valid && t_tag == tag_ff) begin
               off_ff <= NB'(t_off); ord_ff <= t_ord;
               rel_off_ff <= NB'(t_off); rel_ord_ff <= t_ord;
               state_ff <= S_MRG_RD;
            end else if (32'(idx_ff) == TABLE_ENTRIES - 1) begin
               res_ff <= '{bud_pkg::ST_NOT_FOUND, '0, '0}; state_ff <= S_DONE;
            end else begin
               idx_ff <= idx_ff + 1'b1; state_ff <= S_TAG_RD;
            end
            S_MRG_RD: state_ff <= S_MRG_CHK;
            S_MRG_CHK: if (m_rd && 32'(ord_ff) < TOP) begin
               off_ff <= off_ff & ~NB'(1 << ord_ff);
               ord_ff <= ord_ff + 1'b1; state_ff <= S_MRG_RD;
            end else begin
               res_ff <= '{bud_pkg::ST_OK, OFB'(rel_off_ff), rel_ord_ff};
               state_ff <= S_DONE;
            end
            S_DONE: begin
               rsp_valid_ff <= 1'b1; state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // merge at the top order: buddy read is meaningless, so the check above
   // forces the final free write when ord reaches the top
   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff && !m_busy;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, res_ff.order, res_ff.offset, res_ff.status};
endmodule

// ===== rtl/bud_checker.sv =====
module bud_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [23:0] rsp_tdata
);
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("request taken with result pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != bud_pkg::ST_OK |-> rsp_tdata[16:3] == 14'd0)
      else $error("error result with nonzero payload");
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !rsp_tvalid) else $error("result too early");
endmodule

bind buddy_allocator bud_checker u_bud_checker (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata);

// ===== sim/buddy_allocator_tb.sv =====
`timescale 1ns / 1ps

module buddy_allocator_tb;
   localparam int POOL     = 1024;
   localparam int TOP      = 10;
   localparam int ENTRIES  = 64;
   localparam int SMALL    = 8;
   localparam int MAPSZ    = 2048;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   // one pending request: kind, size, tag
   typedef struct packed {
      logic        kind;
      logic [10:0] size;
      logic [15:0] tag;
   } request_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // request_size [10:0], tag [26:11], zero fill
   logic        req_tuser;   // kind
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // status [2:0], block_offset [12:3], block_order [16:13]

   buddy_allocator DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // predictor state: free bitmap per tree node plus the allocation table
   bit          pool_free [MAPSZ];
   bit          slot_used [ENTRIES];
   logic [15:0] slot_tag  [ENTRIES];
   logic [9:0]  slot_off  [ENTRIES];
   logic [3:0]  slot_ord  [ENTRIES];

   request_type pending_reqs[$];
   bud_pkg::result_type expected_grants[$];
   int          errors;
   int          sender_idle;    // percent of cycles the sender holds off
   int          receiver_stall; // percent of cycles the receiver stalls
   logic [15:0] live_tags[$];

   function automatic int tree_node(int order, int offset);
      return (((1 << (TOP - order)) - 1) + (offset >> order)) & (MAPSZ - 1);
   endfunction

   function automatic void pool_reset();
      for (int i = 0; i < MAPSZ; i++) pool_free[i] = 0;
      for (int i = 0; i < ENTRIES; i++) begin
         slot_used[i] = 0;
         slot_tag[i]  = '0;
         slot_off[i]  = '0;
         slot_ord[i]  = '0;
      end
      pool_free[tree_node(TOP, 0)] = 1;
   endfunction

   function automatic bud_pkg::result_type make_result(bud_pkg::status_type st, int off,
                                                       int ord);
      bud_pkg::result_type r;
      r.status = st;
      r.offset = off[9:0];
      r.order  = ord[3:0];
      return r;
   endfunction

   function automatic bud_pkg::result_type grant_block(int size, logic [15:0] tag);
      int rounded, want, slot, j, base, k;
      bit found;
      found = 0;
      base  = 0;
      if (size > POOL) return make_result(bud_pkg::ST_TOO_LARGE, 0, 0);
      rounded = (size < SMALL) ? 2 * SMALL : size;
      want = 0;
      while (want < 31 && (1 << want) < rounded) want++;
      if (want > TOP) return make_result(bud_pkg::ST_TOO_LARGE, 0, 0);
      for (slot = 0; slot < ENTRIES; slot++)
         if (!slot_used[slot]) break;
      if (slot >= ENTRIES) return make_result(bud_pkg::ST_TABLE_FULL, 0, 0);
      for (j = want; j <= TOP; j++) begin
         for (k = 0; k < (1 << (TOP - j)); k++) begin
            if (pool_free[tree_node(j, k << j)]) begin
               base  = k << j;
               found = 1;
               break;
            end
         end
         if (found) break;
      end
      if (!found) return make_result(bud_pkg::ST_NO_FREE, 0, 0);
      pool_free[tree_node(j, base)] = 0;
      // split: lower halves stay free, the top piece is granted
      for (int o = j; o > want; o--)
         pool_free[tree_node(o - 1, base + (1 << j) - (1 << o))] = 1;
      base = base + (1 << j) - (1 << want);
      slot_used[slot] = 1;
      slot_tag[slot]  = tag;
      slot_off[slot]  = base[9:0];
      slot_ord[slot]  = want[3:0];
      return make_result(bud_pkg::ST_OK, base, want);
   endfunction

   function automatic bud_pkg::result_type release_block(logic [15:0] tag);
      int slot, off, o, buddy;
      for (slot = 0; slot < ENTRIES; slot++)
         if (slot_used[slot] && slot_tag[slot] == tag) break;
      if (slot >= ENTRIES) return make_result(bud_pkg::ST_NOT_FOUND, 0, 0);
      slot_used[slot] = 0;
      off = int'(slot_off[slot]);
      o   = int'(slot_ord[slot]);
      // merge with free buddies upward
      while (o < TOP) begin
         buddy = off ^ (1 << o);
         if (!pool_free[tree_node(o, buddy)]) break;
         pool_free[tree_node(o, buddy)] = 0;
         off &= ~(1 << o);
         o++;
      end
      pool_free[tree_node(o, off)] = 1;
      return make_result(bud_pkg::ST_OK, int'(slot_off[slot]), int'(slot_ord[slot]));
   endfunction

   function automatic void push_req(logic kind, int size, logic [15:0] tag);
      request_type r;
      r.kind = kind;
      r.size = size[10:0];
      r.tag  = tag;
      pending_reqs.push_back(r);
   endfunction

   // clock and the single reset pulse
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // driver: takes the next pending request once the previous transfer is done
   always @(posedge clock) begin
      request_type nx;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid && req_tready) begin
            // transfer accepted now: predict from the item that was on the bus
            if (req_tuser == KIND_ALLOC)
               expected_grants.push_back(grant_block(int'(req_tdata[10:0]),
                                                     req_tdata[26:11]));
            else
               expected_grants.push_back(release_block(req_tdata[26:11]));
         end
         if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle) begin
            nx = pending_reqs.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= nx.kind;
            req_tdata  <= {5'd0, nx.tag, nx.size};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver backpressure
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else       rsp_tready <= ($urandom_range(99) >= receiver_stall);
   end

   // monitor: compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      bud_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_grants.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = expected_grants.pop_front();
            if (rsp_tdata[2:0] !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_tdata[2:0]);
               errors++;
            end
            if (rsp_tdata[12:3] !== want.offset) begin
               $display("%0t: offset expected %0d actual %0d", $time, want.offset,
                        rsp_tdata[12:3]);
               errors++;
            end
            if (rsp_tdata[16:13] !== want.order) begin
               $display("%0t: order expected %0d actual %0d", $time, want.order,
                        rsp_tdata[16:13]);
               errors++;
            end
         end
      end
   end

   // random phase: mostly allocs and frees of live tags, some noise
   task automatic fill_random(int n);
      int sz;
      logic [15:0] t;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(9))
            0, 1, 2, 3: begin
               case ($urandom_range(3))
                  0: sz = $urandom_range(7);
                  1: sz = $urandom_range(64);
                  2: sz = $urandom_range(1024);
                  default: sz = $urandom_range(2047);
               endcase
               t = 16'($urandom_range(15));
               if ($urandom_range(3) == 0) t = 16'($urandom);
               push_req(KIND_ALLOC, sz, t);
               live_tags.push_back(t);
            end
            4, 5, 6, 7: begin
               if (live_tags.size() > 0) begin
                  int idx;
                  idx = $urandom_range(live_tags.size() - 1);
                  t = live_tags[idx];
                  live_tags.delete(idx);
               end else t = 16'($urandom);
               push_req(KIND_FREE, $urandom_range(2047), t);
            end
            8: push_req(KIND_FREE, $urandom, 16'($urandom));
            default: push_req(KIND_ALLOC, $urandom_range(32), 16'($urandom));
         endcase
      end
   endtask

   // wait until the queue is drained and nothing is outstanding
   task automatic drain();
      while (pending_reqs.size() > 0 || req_tvalid || expected_grants.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      errors         = 0;
      sender_idle    = 0;
      receiver_stall = 0;
      pool_reset();
      @(negedge reset);
      @(posedge clock);

      // directed: extremes, zero size, non-power sizes, oversize, not found
      push_req(KIND_FREE, 0, 16'h1234);            // tag not found
      push_req(KIND_ALLOC, 1025, 16'h0001);        // too large
      push_req(KIND_ALLOC, 2047, 16'hFFFF);        // too large, all bits
      push_req(KIND_ALLOC, 1024, 16'hFFFF);        // whole pool
      push_req(KIND_ALLOC, 0, 16'h0002);           // no free block
      push_req(KIND_FREE, 0, 16'hFFFF);
      push_req(KIND_ALLOC, 0, 16'h0003);           // zero size -> 16
      push_req(KIND_ALLOC, 7, 16'h0004);
      push_req(KIND_ALLOC, 8, 16'h0005);
      push_req(KIND_ALLOC, 100, 16'h0006);         // rounds up to 128
      push_req(KIND_ALLOC, 513, 16'h0007);         // 1024 no longer free
      push_req(KIND_ALLOC, 3, 16'h0004);           // duplicate tag
      push_req(KIND_FREE, 2047, 16'h0004);         // lowest slot released
      push_req(KIND_FREE, 0, 16'h0004);
      push_req(KIND_FREE, 0, 16'h0003);
      push_req(KIND_FREE, 0, 16'h0005);
      push_req(KIND_FREE, 0, 16'h0006);            // merges back to whole pool
      push_req(KIND_ALLOC, 512, 16'h8000);
      push_req(KIND_FREE, 0, 16'h8000);
      drain();
      // fill the table to reach the table full case, then empty it
      for (int i = 0; i < 65; i++) push_req(KIND_ALLOC, 0, 16'h0100);
      for (int i = 0; i < 65; i++) push_req(KIND_FREE, 0, 16'h0100);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin sender_idle = 0;  receiver_stall = 0;  end
            1: begin sender_idle = 87; receiver_stall = 0;  end
            2: begin sender_idle = 0;  receiver_stall = 87; end
            default: begin sender_idle = 34; receiver_stall = 34; end
         endcase
         fill_random(500);
         drain();
      end

      sender_idle = 0;
      receiver_stall = 0;
      repeat (3000) @(posedge clock);
      if (errors == 0 && expected_grants.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // timeout guard
   initial begin
      #50_000_000;
      $display("FAILED: results differ");
      $finish;
   end
endmodule
